[design/bst_pkg.sv]
package bst_pkg;

    localparam int RESIDUAL_W = 16;
    localparam int SQUARE_W   = 31;
    localparam int MEAN_W     = 15;
    localparam int FACTOR_W   = 16;
    localparam int RATING_W   = 4;
    localparam int OP_W       = 2;
    localparam int USER_W     = 19;
    localparam int MOVIE_W    = 15;
    localparam int OPND_W     = 18;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int DIFF_W     = 18;
    localparam int WIDE_W     = 20;

    localparam logic [MEAN_W-1:0]   MEAN_RESET  = 15'd14759;
    localparam logic [FACTOR_W-1:0] RATE_RESET  = 16'd727;
    localparam logic [FACTOR_W-1:0] REG_RESET   = 16'd2949;
    localparam logic [FACTOR_W-1:0] DECAY_RESET = 16'd58982;

    typedef enum logic [1:0] {
        REG_MEAN  = 2'd0,
        REG_RATE  = 2'd1,
        REG_SHRNK = 2'd2,
        REG_DECAY = 2'd3
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_TRAIN = 2'd0,
        OP_EVAL  = 2'd1,
        OP_EPOCH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PRED,
        ST_SQ,
        ST_SHRINK_U,
        ST_SHRINK_M,
        ST_STEP_U,
        ST_STEP_M,
        ST_WRITE_M,
        ST_DECAY,
        ST_DECAY_WB,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_SQ,
        MUL_SHU,
        MUL_SHM,
        MUL_STU,
        MUL_STM,
        MUL_DECAY
    } mul_sel_t;

    typedef struct packed {
        logic     ready;
        logic     clearing;
        logic     rd_en;
        logic     pred_en;
        mul_sel_t mul_sel;
        logic     sq_en;
        logic     diffu_en;
        logic     diffm_en;
        logic     wr_u;
        logic     wr_m;
        logic     rate_en;
        logic     done;
    } ctrl_t;

endpackage

[design/bst_ram.sv]
module bst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/bst_mul.sv]
module bst_mul (
    input  logic                                  aclk,
    input  logic signed [bst_pkg::OPND_W-1:0]     a,
    input  logic signed [bst_pkg::OPND_W-1:0]     b,
    output logic signed [bst_pkg::PROD_W-1:0]     prod
);

    logic signed [bst_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[design/bst_seq.sv]
module bst_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [bst_pkg::OP_W-1:0] s_op,
    input  logic [bst_pkg::OP_W-1:0] op,
    input  logic                  clr_last,
    input  logic                  out_free,
    output bst_pkg::ctrl_t        ctrl
);

    bst_pkg::state_t state_reg;
    bst_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bst_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bst_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = bst_pkg::ST_IDLE;
                end
            end
            bst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == bst_pkg::OP_EPOCH) begin
                        state_next = bst_pkg::ST_DECAY;
                    end else if (s_op == bst_pkg::OP_NONE) begin
                        state_next = bst_pkg::ST_DONE;
                    end else begin
                        state_next = bst_pkg::ST_READ;
                    end
                end
            end
            bst_pkg::ST_READ:     state_next = bst_pkg::ST_PRED;
            bst_pkg::ST_PRED:     state_next = bst_pkg::ST_SQ;
            bst_pkg::ST_SQ:       state_next = bst_pkg::ST_SHRINK_U;
            bst_pkg::ST_SHRINK_U: begin
                if (op == bst_pkg::OP_TRAIN) begin
                    state_next = bst_pkg::ST_SHRINK_M;
                end else begin
                    state_next = bst_pkg::ST_DONE;
                end
            end
            bst_pkg::ST_SHRINK_M: state_next = bst_pkg::ST_STEP_U;
            bst_pkg::ST_STEP_U:   state_next = bst_pkg::ST_STEP_M;
            bst_pkg::ST_STEP_M:   state_next = bst_pkg::ST_WRITE_M;
            bst_pkg::ST_WRITE_M:  state_next = bst_pkg::ST_DONE;
            bst_pkg::ST_DECAY:    state_next = bst_pkg::ST_DECAY_WB;
            bst_pkg::ST_DECAY_WB: state_next = bst_pkg::ST_DONE;
            bst_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bst_pkg::ST_IDLE;
                end
            end
            default:              state_next = bst_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        ctrl          = '0;
        ctrl.mul_sel  = bst_pkg::MUL_SQ;
        case (state_reg)
            bst_pkg::ST_CLEAR:    ctrl.clearing = 1'b1;
            bst_pkg::ST_IDLE:     ctrl.ready    = 1'b1;
            bst_pkg::ST_READ:     ctrl.rd_en    = 1'b1;
            bst_pkg::ST_PRED:     ctrl.pred_en  = 1'b1;
            bst_pkg::ST_SQ:       ctrl.mul_sel  = bst_pkg::MUL_SQ;
            bst_pkg::ST_SHRINK_U: begin
                ctrl.sq_en    = 1'b1;
                ctrl.mul_sel  = bst_pkg::MUL_SHU;
            end
            bst_pkg::ST_SHRINK_M: begin
                ctrl.diffu_en = 1'b1;
                ctrl.mul_sel  = bst_pkg::MUL_SHM;
            end
            bst_pkg::ST_STEP_U: begin
                ctrl.diffm_en = 1'b1;
                ctrl.mul_sel  = bst_pkg::MUL_STU;
            end
            bst_pkg::ST_STEP_M: begin
                ctrl.wr_u     = 1'b1;
                ctrl.mul_sel  = bst_pkg::MUL_STM;
            end
            bst_pkg::ST_WRITE_M:  ctrl.wr_m     = 1'b1;
            bst_pkg::ST_DECAY:    ctrl.mul_sel  = bst_pkg::MUL_DECAY;
            bst_pkg::ST_DECAY_WB: ctrl.rate_en  = 1'b1;
            bst_pkg::ST_DONE:     ctrl.done     = 1'b1;
            default:              ctrl.clearing = 1'b0;
        endcase
    end

endmodule

[design/bias_sgd_trainer.sv]
// Bias trainer for a baseline rating predictor.
// Input beats carry a user, a movie and a rating in s_tdata and the operation
// in s_tuser: train, evaluate, or end of epoch. Every accepted beat yields
// exactly one result beat on the m_ side with the residual and its square;
// both are zero for an end of epoch or an unused operation code.
// Registers are to be written over the APB port only while the block is idle;
// the block does not enforce this. Writing the initial rate also reloads the
// working rate. After reset the block clears both bias tables, one entry per
// cycle, with s_tready low. A train beat passes through READ, PRED, SQ,
// SHRINK_U, SHRINK_M, STEP_U, STEP_M and WRITE_M, an evaluate beat through READ,
// PRED, SQ and SHRINK_U, an end of epoch through DECAY and DECAY_WB, and an
// unused code goes to DONE. m_tvalid rises as DONE is left, once the output
// register is free, and s_tready rises at that same edge. One 18x18 multiplier
// is shared by the square, both shrink terms, both steps and the rate decay;
// each table is read and written at most once per beat. One beat is in flight
// at a time. The result sits in an output register; while the receiver stalls,
// the block accepts one further beat and then holds it until the register frees.
module bias_sgd_trainer #(
    parameter int USER_INDEX_BITS  = 19,
    parameter int MOVIE_INDEX_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // user_index [18:0], movie_index [33:19], rating [37:34], zero fill
    input  logic [39:0] s_tdata,
    // op [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // residual [15:0], squared_residual [46:16], zero fill
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int UW       = USER_INDEX_BITS;
    localparam int MW       = MOVIE_INDEX_BITS;
    localparam int CLR_BITS = (UW > MW) ? UW : MW;

    localparam int RW  = bst_pkg::RESIDUAL_W;
    localparam int SW  = bst_pkg::SQUARE_W;
    localparam int OW  = bst_pkg::OPND_W;
    localparam int PW  = bst_pkg::PROD_W;
    localparam int DW  = bst_pkg::DIFF_W;
    localparam int XW  = bst_pkg::WIDE_W;
    localparam int FW  = bst_pkg::FACTOR_W;

    function automatic logic signed [XW-1:0] rnd16(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(32768);
        return t[PW-1:16];
    endfunction

    function automatic logic signed [RW-1:0] sat16(input logic signed [XW-1:0] x);
        logic signed [RW-1:0] r;
        if (x > XW'(32767)) begin
            r = 16'sh7FFF;
        end else if (x < -XW'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = x[RW-1:0];
        end
        return r;
    endfunction

    bst_pkg::ctrl_t ctrl;

    logic [bst_pkg::MEAN_W-1:0] mean_reg;
    logic [FW-1:0]              init_rate_reg;
    logic [FW-1:0]              shrink_reg;
    logic [FW-1:0]              decay_reg;
    logic [FW-1:0]              rate_reg;

    logic [CLR_BITS-1:0]        clr_reg;

    logic [bst_pkg::OP_W-1:0]     op_reg;
    logic [UW-1:0]                uaddr_reg;
    logic [MW-1:0]                maddr_reg;
    logic [bst_pkg::RATING_W-1:0] rating_reg;

    logic signed [RW-1:0] res_reg;
    logic signed [RW-1:0] ub_reg;
    logic signed [RW-1:0] mb_reg;
    logic [SW-1:0]        sq_reg;
    logic signed [DW-1:0] diffu_reg;
    logic signed [DW-1:0] diffm_reg;

    logic                 m_tvalid_reg;
    logic signed [RW-1:0] res_out_reg;
    logic [SW-1:0]        sq_out_reg;

    logic                 accept;
    logic                 cfg_wr;
    logic                 out_free;
    logic [UW+bst_pkg::USER_W-1:0]  user_ext;
    logic [MW+bst_pkg::MOVIE_W-1:0] movie_ext;

    logic signed [RW-1:0] ub_rd;
    logic signed [RW-1:0] mb_rd;
    logic signed [XW-1:0] pred_sum;
    logic signed [OW-1:0] opa;
    logic signed [OW-1:0] opb;
    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] rnd;
    logic signed [XW-1:0] diff;
    logic signed [RW-1:0] old_bias;
    logic signed [RW-1:0] new_bias;

    logic          u_we;
    logic [UW-1:0] u_waddr;
    logic [RW-1:0] u_wdata;
    logic          m_we;
    logic [MW-1:0] m_waddr;
    logic [RW-1:0] m_wdata;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = ctrl.ready;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign out_free = ~m_tvalid_reg | m_tready;

    assign user_ext  = {{UW{1'b0}}, s_tdata[18:0]};
    assign movie_ext = {{MW{1'b0}}, s_tdata[33:19]};

    bst_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_op     (s_tuser),
        .op       (op_reg),
        .clr_last (&clr_reg),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Configuration registers and working rate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg      <= bst_pkg::MEAN_RESET;
            init_rate_reg <= bst_pkg::RATE_RESET;
            shrink_reg    <= bst_pkg::REG_RESET;
            decay_reg     <= bst_pkg::DECAY_RESET;
            rate_reg      <= bst_pkg::RATE_RESET;
        end else begin
            if (cfg_wr) begin
                case (bst_pkg::reg_idx_t'(paddr[3:2]))
                    bst_pkg::REG_MEAN:  mean_reg <= pwdata[bst_pkg::MEAN_W-1:0];
                    bst_pkg::REG_RATE: begin
                        init_rate_reg <= pwdata[FW-1:0];
                        rate_reg      <= pwdata[FW-1:0];
                    end
                    bst_pkg::REG_SHRNK: shrink_reg <= pwdata[FW-1:0];
                    bst_pkg::REG_DECAY: decay_reg  <= pwdata[FW-1:0];
                    default:            mean_reg   <= mean_reg;
                endcase
            end else if (ctrl.rate_en) begin
                rate_reg <= rnd[FW-1:0];
            end
        end
    end

    always_comb begin
        case (bst_pkg::reg_idx_t'(paddr[3:2]))
            bst_pkg::REG_MEAN:  prdata = {17'd0, mean_reg};
            bst_pkg::REG_RATE:  prdata = {16'd0, init_rate_reg};
            bst_pkg::REG_SHRNK: prdata = {16'd0, shrink_reg};
            bst_pkg::REG_DECAY: prdata = {16'd0, decay_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (ctrl.clearing) begin
            clr_reg <= clr_reg + CLR_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_tuser;
            uaddr_reg  <= user_ext[UW-1:0];
            maddr_reg  <= movie_ext[MW-1:0];
            rating_reg <= s_tdata[37:34];
        end
    end

    // Bias tables.
    assign u_we    = ctrl.clearing | ctrl.wr_u;
    assign u_waddr = ctrl.clearing ? clr_reg[UW-1:0] : uaddr_reg;
    assign u_wdata = ctrl.clearing ? '0 : new_bias;
    assign m_we    = ctrl.clearing | ctrl.wr_m;
    assign m_waddr = ctrl.clearing ? clr_reg[MW-1:0] : maddr_reg;
    assign m_wdata = ctrl.clearing ? '0 : new_bias;

    bst_ram #(
        .WIDTH (RW),
        .DEPTH (1 << UW)
    ) u_user_ram (
        .aclk  (aclk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (ctrl.rd_en),
        .raddr (uaddr_reg),
        .rdata (ub_rd)
    );

    bst_ram #(
        .WIDTH (RW),
        .DEPTH (1 << MW)
    ) u_movie_ram (
        .aclk  (aclk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (ctrl.rd_en),
        .raddr (maddr_reg),
        .rdata (mb_rd)
    );

    // Prediction and residual.
    assign pred_sum = $signed({4'd0, rating_reg, 12'd0})
                    - ($signed({5'd0, mean_reg})
                       + XW'(ub_rd) + XW'(mb_rd));

    always_ff @(posedge aclk) begin
        if (ctrl.pred_en) begin
            res_reg <= sat16(pred_sum);
            ub_reg  <= ub_rd;
            mb_reg  <= mb_rd;
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (ctrl.mul_sel)
            bst_pkg::MUL_SQ: begin
                opa = OW'(res_reg);
                opb = OW'(res_reg);
            end
            bst_pkg::MUL_SHU: begin
                opa = OW'(ub_reg);
                opb = $signed({2'd0, shrink_reg});
            end
            bst_pkg::MUL_SHM: begin
                opa = OW'(mb_reg);
                opb = $signed({2'd0, shrink_reg});
            end
            bst_pkg::MUL_STU: begin
                opa = $signed({2'd0, rate_reg});
                opb = diffu_reg;
            end
            bst_pkg::MUL_STM: begin
                opa = $signed({2'd0, rate_reg});
                opb = diffm_reg;
            end
            bst_pkg::MUL_DECAY: begin
                opa = $signed({2'd0, rate_reg});
                opb = $signed({2'd0, decay_reg});
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    bst_mul u_mul (
        .aclk (aclk),
        .a    (opa),
        .b    (opb),
        .prod (prod)
    );

    assign rnd      = rnd16(prod);
    assign diff     = XW'(res_reg) - rnd;
    assign old_bias = ctrl.wr_m ? mb_reg : ub_reg;
    assign new_bias = sat16(XW'(old_bias) + rnd);

    always_ff @(posedge aclk) begin
        if (ctrl.sq_en) begin
            sq_reg <= prod[SW-1:0];
        end
        if (ctrl.diffu_en) begin
            diffu_reg <= diff[DW-1:0];
        end
        if (ctrl.diffm_en) begin
            diffm_reg <= diff[DW-1:0];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.done && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.done && out_free) begin
            if (op_reg == bst_pkg::OP_TRAIN || op_reg == bst_pkg::OP_EVAL) begin
                res_out_reg <= res_reg;
                sq_out_reg  <= sq_reg;
            end else begin
                res_out_reg <= '0;
                sq_out_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, sq_out_reg, res_out_reg};

endmodule

[tb/sv/trainer_result_check.sv]
module trainer_result_check
    import bst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          results_due
);

    typedef struct packed {
        logic signed [RESIDUAL_W-1:0] residual;
        logic [SQUARE_W-1:0]          squared;
    } rating_error_t;

    logic [MEAN_W-1:0]   mean_rating;
    logic [FACTOR_W-1:0] start_rate;
    logic [FACTOR_W-1:0] shrink_factor;
    logic [FACTOR_W-1:0] decay_factor;
    logic [FACTOR_W-1:0] learn_rate;

    // Entries that were never trained read as zero.
    bit signed [RESIDUAL_W-1:0] user_offset [int unsigned];
    bit signed [RESIDUAL_W-1:0] movie_offset [int unsigned];

    rating_error_t pending_errors [$];

    function automatic longint clamp16(input longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // Round half up of x / 2^16.
    function automatic longint round_q16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic bit signed [RESIDUAL_W-1:0] nudge_offset(input longint offset,
                                                                input longint residual);
        longint shrink;
        longint step;
        shrink = round_q16(offset * longint'(shrink_factor));
        step   = round_q16(longint'(learn_rate) * (residual - shrink));
        return RESIDUAL_W'(clamp16(offset + step));
    endfunction

    function automatic rating_error_t predict_item(input op_t op, input int unsigned user,
                                                   input int unsigned movie,
                                                   input longint rating);
        rating_error_t outcome;
        longint ub;
        longint mb;
        longint residual;
        outcome = '0;
        if (op == OP_EPOCH) begin
            learn_rate = FACTOR_W'(round_q16(longint'(learn_rate) * longint'(decay_factor)));
        end else if (op == OP_TRAIN || op == OP_EVAL) begin
            ub = user_offset.exists(user) ? user_offset[user] : 0;
            mb = movie_offset.exists(movie) ? movie_offset[movie] : 0;
            residual = clamp16(rating * 4096 - (longint'(mean_rating) + ub + mb));
            outcome.residual = RESIDUAL_W'(residual);
            outcome.squared  = SQUARE_W'(residual * residual);
            if (op == OP_TRAIN) begin
                user_offset[user]   = nudge_offset(ub, residual);
                movie_offset[movie] = nudge_offset(mb, residual);
            end
        end
        return outcome;
    endfunction

    always @(posedge aclk) begin
        rating_error_t want;
        rating_error_t got;
        if (!aresetn) begin
            mean_rating   = MEAN_RESET;
            start_rate    = RATE_RESET;
            shrink_factor = REG_RESET;
            decay_factor  = DECAY_RESET;
            learn_rate    = RATE_RESET;
            user_offset.delete();
            movie_offset.delete();
            pending_errors.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_MEAN: begin
                        mean_rating = pwdata[MEAN_W-1:0];
                    end
                    REG_RATE: begin
                        start_rate = pwdata[FACTOR_W-1:0];
                        learn_rate = pwdata[FACTOR_W-1:0];
                    end
                    REG_SHRNK: begin
                        shrink_factor = pwdata[FACTOR_W-1:0];
                    end
                    REG_DECAY: begin
                        decay_factor = pwdata[FACTOR_W-1:0];
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.residual = m_tdata[RESIDUAL_W-1:0];
                got.squared  = m_tdata[RESIDUAL_W+SQUARE_W-1:RESIDUAL_W];
                if (pending_errors.size() == 0) begin
                    $error("result beat with no item outstanding: residual %0d", got.residual);
                    mismatches++;
                end else begin
                    want = pending_errors.pop_front();
                    if (got.residual !== want.residual) begin
                        $error("residual: expected %0d, got %0d", want.residual, got.residual);
                        mismatches++;
                    end
                    if (got.squared !== want.squared) begin
                        $error("squared_residual: expected %0d, got %0d",
                               want.squared, got.squared);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_errors.push_back(predict_item(
                    op_t'(s_tuser),
                    s_tdata[USER_W-1:0],
                    s_tdata[USER_W+MOVIE_W-1:USER_W],
                    longint'(s_tdata[USER_W+MOVIE_W+RATING_W-1:USER_W+MOVIE_W])));
            end
        end
        results_due <= pending_errors.size();
    end

endmodule

[tb/sv/tb_bias_sgd_trainer.sv]
module tb_bias_sgd_trainer;
    import bst_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES          = 8;
    localparam int POOL_SIZE       = 8;
    localparam int WATCHDOG_LIMIT  = 3 * (1 << USER_W);

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int results_due;
    int holds_requested = 0;
    bit steady_send     = 1'b0;
    bit steady_recv     = 1'b0;

    logic [USER_W-1:0]  user_pool  [POOL_SIZE];
    logic [MOVIE_W-1:0] movie_pool [POOL_SIZE];

    always #1 aclk = ~aclk;

    bias_sgd_trainer #(
        .USER_INDEX_BITS  (USER_W),
        .MOVIE_INDEX_BITS (MOVIE_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    trainer_result_check result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic offer_beat(input op_t op, input logic [USER_W-1:0] user,
                              input logic [MOVIE_W-1:0] movie,
                              input logic [RATING_W-1:0] rating);
        int gap;
        @(negedge aclk);
        gap = steady_send ? 0 : draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, rating, movie, user};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic offer_random_item();
        int pick;
        op_t op;
        logic [USER_W-1:0] user;
        logic [MOVIE_W-1:0] movie;
        logic [RATING_W-1:0] rating;
        pick = $urandom_range(99);
        if (pick < 60) op = OP_TRAIN;
        else if (pick < 93) op = OP_EVAL;
        else if (pick < 97) op = OP_EPOCH;
        else op = OP_NONE;
        user = ($urandom_range(3) == 0) ? USER_W'($urandom)
                                        : user_pool[$urandom_range(POOL_SIZE - 1)];
        movie = ($urandom_range(3) == 0) ? MOVIE_W'($urandom)
                                         : movie_pool[$urandom_range(POOL_SIZE - 1)];
        rating = ($urandom_range(9) == 0) ? RATING_W'($urandom)
                                          : RATING_W'($urandom_range(8, 1));
        offer_beat(op, user, movie, rating);
    endtask

    // Once every outstanding result has come back, the block is idle.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (results_due == 0);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Junk above each register's width checks that the block masks it.
    task automatic load_settings(input int mean, input int rate, input int shrink,
                                 input int decay);
        apb_write(REG_MEAN, (32'($urandom) & 32'hFFFF_8000) | 32'(mean));
        apb_write(REG_RATE, (32'($urandom) & 32'hFFFF_0000) | 32'(rate));
        apb_write(REG_SHRNK, (32'($urandom) & 32'hFFFF_0000) | 32'(shrink));
        apb_write(REG_DECAY, (32'($urandom) & 32'hFFFF_0000) | 32'(decay));
    endtask

    initial begin : receiver
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (holds_served != holds_requested) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = steady_recv ? 0 : draw_gap();
            end
        end
    end

    // Reset is followed by a clearing pass over the larger table with s_tready low.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb_bias_sgd_trainer: done, errors");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        offer_beat(OP_TRAIN, '0, '0, 4'd1);
        offer_beat(OP_EVAL, '0, '0, 4'd8);
        offer_beat(OP_TRAIN, '1, '1, 4'd8);
        offer_beat(OP_EVAL, '1, '1, 4'd15);
        offer_beat(OP_EVAL, '0, '1, 4'd0);
        offer_beat(OP_NONE, USER_W'($urandom), MOVIE_W'($urandom), RATING_W'($urandom));
        offer_beat(OP_EPOCH, USER_W'($urandom), MOVIE_W'($urandom), RATING_W'($urandom));
        offer_beat(OP_TRAIN, '0, '0, 4'd9);
        offer_beat(OP_TRAIN, 19'h2AAAA, 15'h5555, 4'hA);
        offer_beat(OP_TRAIN, 19'h55555, 15'h2AAA, 4'h5);
        drain_results();

        // Full rate and no shrinkage drive one movie offset into saturation.
        load_settings(0, 16'hFFFF, 0, 16'hFFFF);
        offer_beat(OP_TRAIN, 19'd3, 15'd9, 4'd15);
        offer_beat(OP_TRAIN, 19'd4, 15'd9, 4'd15);
        offer_beat(OP_EVAL, 19'd5, 15'd9, 4'd15);
        drain_results();

        // The largest mean pushes the residual to its negative limit; a zero decay
        // then stops all learning.
        load_settings(15'h7FFF, 16'hFFFF, 16'hFFFF, 0);
        offer_beat(OP_EVAL, 19'd6, 15'd9, 4'd0);
        offer_beat(OP_TRAIN, 19'd6, 15'd9, 4'd0);
        offer_beat(OP_TRAIN, 19'd3, 15'd9, 4'd0);
        offer_beat(OP_EPOCH, USER_W'($urandom), MOVIE_W'($urandom), RATING_W'($urandom));
        offer_beat(OP_TRAIN, 19'd3, 15'd9, 4'd8);
        offer_beat(OP_EVAL, 19'd3, 15'd9, 4'd8);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: load_settings(MEAN_RESET, RATE_RESET, REG_RESET, DECAY_RESET);
                1: load_settings(0, 16'hFFFF, 0, 16'hFFFF);
                2: load_settings(15'h7FFF, 16'hFFFF, 16'hFFFF, 0);
                default: load_settings($urandom_range(32767), $urandom_range(65535),
                                       $urandom_range(65535), $urandom_range(65535));
            endcase
            user_pool[0]  = '0;
            user_pool[1]  = '1;
            movie_pool[0] = '0;
            movie_pool[1] = '1;
            for (int k = 2; k < POOL_SIZE; k++) begin
                user_pool[k]  = USER_W'($urandom);
                movie_pool[k] = MOVIE_W'($urandom);
            end
            steady_send = (phase == 3 || phase == 5);
            steady_recv = (phase == 4 || phase == 5);
            if (phase == 2 || phase == 6) holds_requested++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_random_item();
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_bias_sgd_trainer: done, clean");
        end else begin
            $display("tb_bias_sgd_trainer: done, errors");
        end
        $finish;
    end

endmodule
